[design/bfs_pkg.sv]
// Shared types and constants of the bitmap find-and-set block.
package bfs_pkg;

   localparam int MAX_BITS_DEF = 4096;
   localparam int BYTE_BITS    = 8;
   localparam int CSR_W        = 13;
   localparam int POS_W        = 12;
   localparam int OUTCOME_W    = 2;

   localparam logic [CSR_W-1:0] BITS_IN_USE_RST = 13'd4096;

   localparam logic KIND_SEARCH = 1'b0;
   localparam logic KIND_WRITE  = 1'b1;

   localparam logic [OUTCOME_W-1:0] OUT_OK        = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUT_NOT_FOUND = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUT_RANGE     = 2'd2;

   typedef struct packed {
      logic             kind;
      logic [POS_W-1:0] position;
      logic             bit_value;
   } req_type;

   typedef struct packed {
      logic [OUTCOME_W-1:0] outcome;
      logic [POS_W-1:0]     found_position;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_MODIFY,
      ST_RESULT
   } state_type;

endpackage

[design/bitmap_find_and_set.sv]
// Bitmap find-and-set block: byte-wide bitmap memory with search and bit write.
// Sequence: a search checks one byte after another, up to (MAX_BITS+7)/8 bytes
// (512 at default size), until a match or the last byte; a write reads, modifies
// and writes back the byte; out-of-range and empty searches skip to the result.
// Throughput: one item at a time; a new request is stalled until the block is idle.
// Reset: synchronous; the memory is then cleared one byte a cycle while no request
// is taken.
module bitmap_find_and_set
   import bfs_pkg::*;
#(
   parameter int MAX_BITS = MAX_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   // result channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   // register write channel
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CSR_W-1:0] csr_data
);

   // Sizes derived from the bitmap capacity.
   localparam int MAP_BYTES = (MAX_BITS + BYTE_BITS - 1) / BYTE_BITS;
   localparam int ADDR_W    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
   localparam int CNT_RAW_W = $clog2(MAX_BITS + 1);
   localparam int CNT_W     = (CNT_RAW_W > CSR_W) ? CNT_RAW_W : CSR_W;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_BYTES - 1);
   localparam logic [CNT_W-1:0]  CAP       = CNT_W'(MAX_BITS);

   // Bitmap storage: one write port, one registered read port.
   logic [BYTE_BITS-1:0] mem [MAP_BYTES];
   logic [BYTE_BITS-1:0] mem_rd_ff;
   logic                 mem_re;
   logic [ADDR_W-1:0]    mem_raddr;
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   logic [BYTE_BITS-1:0] mem_wdata;

   // Control and working registers.
   state_type            state_ff, state_in;
   logic [CSR_W-1:0]     bits_in_use_ff;
   logic [ADDR_W-1:0]    clr_addr_ff, clr_addr_in;
   logic [ADDR_W-1:0]    rd_addr_ff, rd_addr_in;
   logic [ADDR_W-1:0]    ev_addr_ff, ev_addr_in;
   logic [CNT_W-1:0]     start_ff, start_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 want_ff, want_in;
   logic [OUTCOME_W-1:0] res_outcome_ff, res_outcome_in;
   logic [POS_W-1:0]     res_pos_ff, res_pos_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   // Request decode and scan evaluation.
   logic                 req_xfer;
   logic                 rsp_free;
   logic [CNT_W-1:0]     req_pos;
   logic [ADDR_W-1:0]    req_addr;
   logic [CNT_W-1:0]     csr_count;
   logic [CNT_W-1:0]     active_count;
   logic [CNT_W-1:0]     ev_base;
   logic [CNT_W-1:0]     bit_pos [BYTE_BITS];
   logic [BYTE_BITS-1:0] hit;
   logic                 any_hit;
   logic [CNT_W-1:0]     hit_pos;
   logic                 last_byte;
   logic                 mod_bit;
   logic [BYTE_BITS-1:0] mod_byte;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Clamp the register to the capacity.
   assign csr_count    = CNT_W'(bits_in_use_ff);
   assign active_count = (csr_count > CAP) ? CAP : csr_count;

   assign req_pos  = CNT_W'(req_data.position);
   assign req_addr = req_pos[ADDR_W+2:3];

   // Positions covered by the byte on the read port; bit 0 sits at the MSB.
   assign ev_base = CNT_W'({ev_addr_ff, 3'b000});

   always_comb begin
      for (int j = 0; j < BYTE_BITS; j++) begin
         bit_pos[j] = ev_base + CNT_W'(j);
         hit[j]     = (bit_pos[j] >= start_ff) && (bit_pos[j] < count_ff)
                      && (mem_rd_ff[BYTE_BITS-1-j] == want_ff);
      end
   end

   // Lowest matching position wins.
   always_comb begin
      hit_pos = '0;
      for (int j = BYTE_BITS - 1; j >= 0; j--) begin
         if (hit[j]) begin
            hit_pos = bit_pos[j];
         end
      end
   end

   assign any_hit   = |hit;
   assign last_byte = (ev_base + CNT_W'(BYTE_BITS)) >= count_ff;

   // Read-modify-write of one bit; start_ff holds the write position.
   always_comb begin
      mod_byte = mem_rd_ff;
      mod_bit  = 1'b0;
      for (int j = 0; j < BYTE_BITS; j++) begin
         mod_bit = (start_ff[2:0] == 3'(j));
         if (mod_bit) begin
            mod_byte[BYTE_BITS-1-j] = want_ff;
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_data.kind == KIND_SEARCH) begin
                  state_in = (req_pos < active_count) ? ST_SCAN : ST_RESULT;
               end else begin
                  state_in = (req_pos < active_count) ? ST_MODIFY : ST_RESULT;
               end
            end
         end
         ST_SCAN: begin
            if (any_hit || last_byte) begin
               state_in = ST_RESULT;
            end
         end
         ST_MODIFY: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Datapath, memory and result controls.
   always_comb begin
      mem_re         = 1'b0;
      mem_raddr      = rd_addr_ff;
      mem_we         = 1'b0;
      mem_waddr      = ev_addr_ff;
      mem_wdata      = mod_byte;
      clr_addr_in    = clr_addr_ff;
      rd_addr_in     = rd_addr_ff;
      ev_addr_in     = ev_addr_ff;
      start_in       = start_ff;
      count_in       = count_ff;
      want_in        = want_ff;
      res_outcome_in = res_outcome_ff;
      res_pos_in     = res_pos_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_CLEAR: begin
            // Zero one byte a cycle.
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_xfer) begin
               // Fetch the first byte at once; it is unused on a range miss.
               mem_re     = 1'b1;
               mem_raddr  = req_addr;
               rd_addr_in = req_addr + 1'b1;
               ev_addr_in = req_addr;
               start_in   = req_pos;
               count_in   = active_count;
               want_in    = req_data.bit_value;
               res_pos_in = '0;
               if (req_data.kind == KIND_SEARCH) begin
                  if (req_pos > active_count) begin
                     res_outcome_in = OUT_RANGE;
                  end else begin
                     res_outcome_in = OUT_NOT_FOUND;
                  end
               end else begin
                  if (req_pos >= active_count) begin
                     res_outcome_in = OUT_RANGE;
                  end else begin
                     res_outcome_in = OUT_OK;
                  end
               end
            end
         end
         ST_SCAN: begin
            // Evaluate the byte on the read port, fetch the next one.
            mem_re     = (rd_addr_ff <= LAST_ADDR);
            mem_raddr  = rd_addr_ff;
            ev_addr_in = rd_addr_ff;
            rd_addr_in = rd_addr_ff + 1'b1;
            if (any_hit) begin
               res_outcome_in = OUT_OK;
               res_pos_in     = hit_pos[POS_W-1:0];
            end
         end
         ST_MODIFY: begin
            mem_we = 1'b1;
         end
         ST_RESULT: begin
            if (rsp_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.outcome        = res_outcome_ff;
               rsp_data_in.found_position = res_pos_ff;
            end
         end
         default: begin
            mem_re = 1'b0;
         end
      endcase
   end

   // Bitmap memory.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rd_ff <= mem[mem_raddr];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_addr_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
         bits_in_use_ff <= BITS_IN_USE_RST;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            bits_in_use_ff <= csr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rd_addr_ff     <= rd_addr_in;
      ev_addr_ff     <= ev_addr_in;
      start_ff       <= start_in;
      count_ff       <= count_in;
      want_ff        <= want_in;
      res_outcome_ff <= res_outcome_in;
      res_pos_ff     <= res_pos_in;
      rsp_data_ff    <= rsp_data_in;
   end

endmodule
